>>> rtl/csa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csa_pkg;

    localparam int CMD_W      = 2;
    localparam int ID_IN_W    = 8;
    localparam int SIZE_W     = 21;
    localparam int STRAT_W    = 2;
    localparam int STATUS_W   = 3;
    localparam int OUT_ADDR_W = 20;
    localparam int OUT_ID_W   = 8;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd3;

    localparam logic [STRAT_W-1:0] STRAT_FIRST   = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST    = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST   = 2'd2;
    localparam logic [STRAT_W-1:0] STRAT_INVALID = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STRAT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ID     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_REPORT    = 3'd6;

    // what a cell does: hold, write, shift up or shift down
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_WRITE = 2'd1,
        OP_SHUP  = 2'd2,
        OP_SHDN  = 2'd3
    } cell_op_t;

endpackage
`default_nettype wire

>>> rtl/csa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module csa_cell #(
    parameter int SEGMENTS = 16,
    parameter int IDX      = 0,
    parameter int EW       = 49
) (
    input  wire                          aclk,
    input  csa_pkg::cell_op_t            op,
    input  wire [$clog2(SEGMENTS)-1:0]   pos,
    input  wire [EW-1:0]                 wdata,
    input  wire [EW-1:0]                 lo,
    input  wire [EW-1:0]                 hi,
    output logic [EW-1:0]                q
);
    import csa_pkg::*;

    localparam int PW = $clog2(SEGMENTS);
    localparam logic [PW-1:0] MY_POS = PW'(IDX);

    logic [EW-1:0] q_reg;
    logic [EW-1:0] q_next;

    always_comb begin
        q_next = q_reg;
        case (op)
            OP_WRITE: begin
                if (pos == MY_POS) q_next = wdata;
            end
            // open a slot: cells above pos take their lower neighbor
            OP_SHUP: begin
                if (MY_POS > pos) q_next = lo;
            end
            // close a slot: cells from pos up take their upper neighbor
            OP_SHDN: begin
                if (MY_POS >= pos) q_next = hi;
            end
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

>>> rtl/contiguous_segment_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    tdata: proc_id, req_size; tuser: cmd, strategy
// m_        out  m_tvalid / m_tready    tdata: start, end, owner, is_free; tuser: status; tlast
// cfg_w     in   cfg_wvalid / cfg_wready cfg_wdata: mem_size
//
// the table sits in a row of cells with one read port, scanned one entry a cycle;
// the report scan waits while a held result has not been taken
// a report sends one result per segment, the last one with tlast set
// after reset the init state loads the single free segment before requests are taken
// one command is worked at a time; a held result only stalls the next emission
module contiguous_segment_allocator_core #(
    parameter int SEGMENTS  = 16,
    parameter int ADDR_BITS = 20,
    parameter int ID_BITS   = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,     // proc_id[7:0], req_size[28:8], zero pad
    input  wire  [3:0]  s_tuser,     // cmd[1:0], strategy[3:2]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,     // start[19:0], end[39:20], owner[47:40], is_free[48]
    output logic [2:0]  m_tuser,     // status[2:0]
    output logic        m_tlast,
    input  wire         cfg_wvalid,
    output logic        cfg_wready,
    input  wire  [20:0] cfg_wdata    // mem_size
);
    import csa_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int IB = ID_BITS;
    localparam int PW = $clog2(SEGMENTS);
    localparam int CW = $clog2(SEGMENTS + 1);
    localparam int EW = 2 * AW + IB + 1;
    localparam int MW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam int OW = (AW > OUT_ADDR_W) ? AW : OUT_ADDR_W;
    localparam int OI = (IB > OUT_ID_W) ? IB : OUT_ID_W;
    localparam logic [MW-1:0] CAP = MW'(1) << AW;
    localparam logic [AW:0] RESET_MEM = (AW > 20) ? ((AW + 1)'(1) << 20)
                                                  : ((AW + 1)'(1) << AW);

    typedef enum logic [16:0] {
        S_INIT     = 17'h00001,
        S_IDLE     = 17'h00002,
        S_REQ_SCAN = 17'h00004,
        S_REQ_DEC  = 17'h00008,
        S_REQ_REM  = 17'h00010,
        S_REQ_OWN  = 17'h00020,
        S_REL_SCAN = 17'h00040,
        S_REL_FREE = 17'h00080,
        S_REL_NEXT = 17'h00100,
        S_REL_NSH  = 17'h00200,
        S_REL_PCHK = 17'h00400,
        S_REL_PREV = 17'h00800,
        S_REL_PSH  = 17'h01000,
        S_CMP_SCAN = 17'h02000,
        S_CMP_TAIL = 17'h04000,
        S_RPT      = 17'h08000,
        S_EMIT     = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [AW:0]          mem_reg, mem_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [PW-1:0]        idx_reg, idx_next;
    logic [PW-1:0]        pick_reg, pick_next;
    logic                 found_reg, found_next;
    logic [AW:0]          pick_len_reg, pick_len_next;
    logic [AW-1:0]        pick_start_reg, pick_start_next;
    logic [AW-1:0]        pick_end_reg, pick_end_next;
    logic [AW-1:0]        cur_end_reg, cur_end_next;
    logic [CW-1:0]        w_reg, w_next;
    logic [AW:0]          addr_reg, addr_next;
    logic [IB-1:0]        id_reg, id_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [STRAT_W-1:0]   strat_reg, strat_next;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [AW-1:0]        res_start_reg, res_start_next;
    logic [AW-1:0]        res_end_reg, res_end_next;
    logic [IB-1:0]        res_owner_reg, res_owner_next;
    logic                 res_free_reg, res_free_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [OUT_ADDR_W-1:0] out_start_reg, out_start_next;
    logic [OUT_ADDR_W-1:0] out_end_reg, out_end_next;
    logic [OUT_ID_W-1:0]  out_owner_reg, out_owner_next;
    logic                 out_free_reg, out_free_next;
    logic                 out_last_reg, out_last_next;

    cell_op_t             c_op;
    logic [PW-1:0]        c_pos;
    logic [EW-1:0]        c_wdata;
    logic [EW-1:0]        cell_q [SEGMENTS];

    logic [EW-1:0]        rd;
    logic [AW-1:0]        rd_start, rd_end;
    logic [IB-1:0]        rd_owner;
    logic                 rd_used;
    logic [AW:0]          rd_len;
    logic                 rd_fit, rd_take, rd_last;
    logic                 out_free;
    logic [MW-1:0]        cfg_v;
    logic [AW:0]          cfg_mem;
    logic [CMD_W-1:0]     in_cmd;
    logic [STRAT_W-1:0]   in_strat;
    logic [SIZE_W-1:0]    in_size;
    logic [OW-1:0]        ext_start, ext_end;
    logic [OI-1:0]        ext_owner;
    logic [AW-1:0]        split_end;

    // ---- cell row
    for (genvar g = 0; g < SEGMENTS; g++) begin : g_cell
        logic [EW-1:0] lo_w, hi_w;
        if (g == 0) begin : g_lo0
            assign lo_w = '0;
        end else begin : g_lo
            assign lo_w = cell_q[g-1];
        end
        if (g == SEGMENTS - 1) begin : g_hiN
            assign hi_w = '0;
        end else begin : g_hi
            assign hi_w = cell_q[g+1];
        end
        csa_cell #(.SEGMENTS(SEGMENTS), .IDX(g), .EW(EW)) u_cell (
            .aclk  (aclk),
            .op    (c_op),
            .pos   (c_pos),
            .wdata (c_wdata),
            .lo    (lo_w),
            .hi    (hi_w),
            .q     (cell_q[g])
        );
    end

    assign rd       = cell_q[idx_reg];
    assign rd_start = rd[AW-1:0];
    assign rd_end   = rd[2*AW-1:AW];
    assign rd_owner = rd[2*AW+IB-1:2*AW];
    assign rd_used  = rd[EW-1];
    assign rd_len   = (AW + 1)'(rd_end) - (AW + 1)'(rd_start) + (AW + 1)'(1);
    assign rd_fit   = !rd_used && (MW'(rd_len) >= MW'(size_reg));
    assign rd_take  = rd_fit && (!found_reg
                      || (strat_reg == STRAT_BEST && rd_len < pick_len_reg)
                      || (strat_reg == STRAT_WORST && rd_len > pick_len_reg));
    assign rd_last  = (CW'(idx_reg) == count_reg - CW'(1));
    assign split_end = pick_start_reg + AW'(size_reg) - AW'(1);

    assign out_free = !out_valid_reg || m_tready;

    assign in_cmd   = s_tuser[1:0];
    assign in_strat = s_tuser[3:2];
    assign in_size  = s_tdata[28:8];

    // clamp of the written memory size
    always_comb begin
        cfg_v = MW'(cfg_wdata);
        if (cfg_v == '0) cfg_v = MW'(1);
        if (cfg_v > CAP) cfg_v = CAP;
        cfg_mem = (AW + 1)'(cfg_v);
    end

    assign s_tready   = (state_reg == S_IDLE) && !cfg_wvalid;
    assign cfg_wready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        mem_next        = mem_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        pick_len_next   = pick_len_reg;
        pick_start_next = pick_start_reg;
        pick_end_next   = pick_end_reg;
        cur_end_next    = cur_end_reg;
        w_next          = w_reg;
        addr_next       = addr_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        strat_next      = strat_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        res_owner_next  = res_owner_reg;
        res_free_next   = res_free_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_owner_next  = out_owner_reg;
        out_free_next   = out_free_reg;
        out_last_next   = out_last_reg;
        ext_start       = OW'(res_start_reg);
        ext_end         = OW'(res_end_reg);
        ext_owner       = OI'(res_owner_reg);
        c_op            = OP_HOLD;
        c_pos           = '0;
        c_wdata         = '0;

        case (state_reg)
            S_INIT: begin
                c_op       = OP_WRITE;
                c_wdata    = {1'b0, IB'(0), AW'(mem_reg - (AW + 1)'(1)), AW'(0)};
                count_next = CW'(1);
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_wvalid) begin
                    mem_next   = cfg_mem;
                    c_op       = OP_WRITE;
                    c_wdata    = {1'b0, IB'(0), AW'(cfg_mem - (AW + 1)'(1)), AW'(0)};
                    count_next = CW'(1);
                end else if (s_tvalid) begin
                    id_next         = IB'(s_tdata[7:0]);
                    size_next       = in_size;
                    strat_next      = in_strat;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    w_next          = '0;
                    addr_next       = '0;
                    res_status_next = ST_OK;
                    res_start_next  = '0;
                    res_end_next    = '0;
                    res_owner_next  = '0;
                    res_free_next   = 1'b0;
                    case (in_cmd)
                        CMD_REQUEST: begin
                            if (in_size == '0) begin
                                res_status_next = ST_BAD_SIZE;
                                state_next      = S_EMIT;
                            end else if (in_strat == STRAT_INVALID) begin
                                res_status_next = ST_BAD_STRAT;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_REQ_SCAN;
                            end
                        end
                        CMD_RELEASE: state_next = S_REL_SCAN;
                        CMD_COMPACT: state_next = S_CMP_SCAN;
                        default:     state_next = S_RPT;
                    endcase
                end
            end
            S_REQ_SCAN: begin
                if (rd_take) begin
                    found_next      = 1'b1;
                    pick_next       = idx_reg;
                    pick_len_next   = rd_len;
                    pick_start_next = rd_start;
                    pick_end_next   = rd_end;
                end
                if (rd_last || (strat_reg == STRAT_FIRST && rd_fit)) begin
                    state_next = S_REQ_DEC;
                end else begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            S_REQ_DEC: begin
                if (!found_reg) begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_EMIT;
                end else if (MW'(pick_len_reg) > MW'(size_reg)) begin
                    if (count_reg >= CW'(SEGMENTS)) begin
                        res_status_next = ST_FULL;
                        state_next      = S_EMIT;
                    end else begin
                        c_op       = OP_SHUP;
                        c_pos      = pick_reg;
                        count_next = count_reg + CW'(1);
                        state_next = S_REQ_REM;
                    end
                end else begin
                    state_next = S_REQ_OWN;
                end
            end
            S_REQ_REM: begin
                // free remainder right above the owned part
                c_op       = OP_WRITE;
                c_pos      = pick_reg + PW'(1);
                c_wdata    = {1'b0, IB'(0), pick_end_reg, split_end + AW'(1)};
                state_next = S_REQ_OWN;
            end
            S_REQ_OWN: begin
                c_op           = OP_WRITE;
                c_pos          = pick_reg;
                res_start_next = pick_start_reg;
                res_end_next   = (MW'(pick_len_reg) > MW'(size_reg)) ? split_end
                                                                     : pick_end_reg;
                res_owner_next = id_reg;
                c_wdata        = {1'b1, id_reg, res_end_next, pick_start_reg};
                state_next     = S_EMIT;
            end
            S_REL_SCAN: begin
                if (rd_used && rd_owner == id_reg) begin
                    pick_next      = idx_reg;
                    cur_end_next   = rd_end;
                    res_start_next = rd_start;
                    res_end_next   = rd_end;
                    res_owner_next = id_reg;
                    res_free_next  = 1'b1;
                    state_next     = S_REL_FREE;
                end else if (rd_last) begin
                    res_status_next = ST_NO_ID;
                    state_next      = S_EMIT;
                end else begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            S_REL_FREE: begin
                c_op    = OP_WRITE;
                c_pos   = pick_reg;
                c_wdata = {1'b0, IB'(0), res_end_reg, res_start_reg};
                if (CW'(pick_reg) + CW'(1) < count_reg) begin
                    idx_next   = pick_reg + PW'(1);
                    state_next = S_REL_NEXT;
                end else begin
                    state_next = S_REL_PCHK;
                end
            end
            S_REL_NEXT: begin
                if (!rd_used) begin
                    cur_end_next = rd_end;
                    c_op         = OP_WRITE;
                    c_pos        = pick_reg;
                    c_wdata      = {1'b0, IB'(0), rd_end, res_start_reg};
                    state_next   = S_REL_NSH;
                end else begin
                    state_next = S_REL_PCHK;
                end
            end
            S_REL_NSH: begin
                c_op       = OP_SHDN;
                c_pos      = pick_reg + PW'(1);
                count_next = count_reg - CW'(1);
                state_next = S_REL_PCHK;
            end
            S_REL_PCHK: begin
                if (pick_reg != '0) begin
                    idx_next   = pick_reg - PW'(1);
                    state_next = S_REL_PREV;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_REL_PREV: begin
                if (!rd_used) begin
                    c_op       = OP_WRITE;
                    c_pos      = idx_reg;
                    c_wdata    = {1'b0, IB'(0), cur_end_reg, rd_start};
                    state_next = S_REL_PSH;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_REL_PSH: begin
                c_op       = OP_SHDN;
                c_pos      = pick_reg;
                count_next = count_reg - CW'(1);
                state_next = S_EMIT;
            end
            S_CMP_SCAN: begin
                // write pointer never passes the read pointer
                if (rd_used) begin
                    c_op      = OP_WRITE;
                    c_pos     = PW'(w_reg);
                    c_wdata   = {1'b1, rd_owner, AW'(addr_reg + rd_len - (AW + 1)'(1)),
                                 AW'(addr_reg)};
                    addr_next = addr_reg + rd_len;
                    w_next    = w_reg + CW'(1);
                end
                if (rd_last) begin
                    state_next = S_CMP_TAIL;
                end else begin
                    idx_next = idx_reg + PW'(1);
                end
            end
            S_CMP_TAIL: begin
                if (addr_reg < mem_reg && w_reg < CW'(SEGMENTS)) begin
                    c_op       = OP_WRITE;
                    c_pos      = PW'(w_reg);
                    c_wdata    = {1'b0, IB'(0), AW'(mem_reg - (AW + 1)'(1)), AW'(addr_reg)};
                    count_next = w_reg + CW'(1);
                end else begin
                    count_next = w_reg;
                end
                state_next = S_EMIT;
            end
            S_RPT: begin
                if (out_free) begin
                    ext_start       = OW'(rd_start);
                    ext_end         = OW'(rd_end);
                    ext_owner       = rd_used ? OI'(rd_owner) : '0;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_REPORT;
                    out_start_next  = ext_start[OUT_ADDR_W-1:0];
                    out_end_next    = ext_end[OUT_ADDR_W-1:0];
                    out_owner_next  = ext_owner[OUT_ID_W-1:0];
                    out_free_next   = !rd_used;
                    out_last_next   = rd_last;
                    if (rd_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + PW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = ext_start[OUT_ADDR_W-1:0];
                    out_end_next    = ext_end[OUT_ADDR_W-1:0];
                    out_owner_next  = ext_owner[OUT_ID_W-1:0];
                    out_free_next   = res_free_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            mem_reg       <= RESET_MEM;
            count_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mem_reg       <= mem_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        pick_reg       <= pick_next;
        found_reg      <= found_next;
        pick_len_reg   <= pick_len_next;
        pick_start_reg <= pick_start_next;
        pick_end_reg   <= pick_end_next;
        cur_end_reg    <= cur_end_next;
        w_reg          <= w_next;
        addr_reg       <= addr_next;
        id_reg         <= id_next;
        size_reg       <= size_next;
        strat_reg      <= strat_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        res_owner_reg  <= res_owner_next;
        res_free_reg   <= res_free_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_owner_reg  <= out_owner_next;
        out_free_reg   <= out_free_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_free_reg, out_owner_reg, out_end_reg, out_start_reg};

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CW'(SEGMENTS))
        else $error("segment count out of range");

    a_split_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_REQ_REM |-> count_reg == $past(count_reg) + CW'(1))
        else $error("split did not add a segment");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != ST_REPORT |-> out_last_reg)
        else $error("non-report result without last");

    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wvalid && cfg_wready |=> count_reg == CW'(1))
        else $error("config write did not reset the table");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import csa_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_ADDR_W-1:0] start_addr;
        logic [OUT_ADDR_W-1:0] end_addr;
        logic [OUT_ID_W-1:0]   owner;
        logic                  is_free;
        logic                  last;
    } reply_t;

    // tracks the segment table and the replies each request should bring
    class segment_table_model;
        bit [19:0] seg_start [TABLE_DEPTH];
        bit [19:0] seg_end   [TABLE_DEPTH];
        bit [7:0]  seg_owner [TABLE_DEPTH];
        bit        seg_used  [TABLE_DEPTH];
        int        seg_count;
        bit [20:0] mem_units;
        reply_t    expected_replies[$];
        int        errors;

        function void clear_table();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                seg_start[i] = 0;
                seg_end[i] = 0;
                seg_owner[i] = 0;
                seg_used[i] = 0;
            end
            seg_end[0] = 20'(mem_units - 1);
            seg_count = 1;
        endfunction

        function void set_mem_size(bit [20:0] v);
            if (v == 0) v = 1;
            if (v > 21'h100000) v = 21'h100000;
            mem_units = v;
            clear_table();
        endfunction

        function void push(logic [STATUS_W-1:0] st, bit [19:0] s, bit [19:0] e, bit [7:0] o,
                           bit f, bit l);
            reply_t r;
            r.status = st;
            r.start_addr = s;
            r.end_addr = e;
            r.owner = o;
            r.is_free = f;
            r.last = l;
            expected_replies.push_back(r);
        endfunction

        function void drop_entry(int i);
            for (int j = i; j + 1 < seg_count; j++) begin
                seg_start[j] = seg_start[j+1];
                seg_end[j] = seg_end[j+1];
                seg_owner[j] = seg_owner[j+1];
                seg_used[j] = seg_used[j+1];
            end
            seg_count--;
            seg_start[seg_count] = 0;
            seg_end[seg_count] = 0;
            seg_owner[seg_count] = 0;
            seg_used[seg_count] = 0;
        endfunction

        function void allocate(bit [7:0] id, bit [20:0] size, logic [STRAT_W-1:0] strat);
            int pick;
            bit [20:0] pick_len;
            bit [20:0] len;
            pick = -1;
            pick_len = 0;
            if (size == 0) begin
                push(ST_BAD_SIZE, 0, 0, 0, 0, 1);
                return;
            end
            if (strat == STRAT_INVALID) begin
                push(ST_BAD_STRAT, 0, 0, 0, 0, 1);
                return;
            end
            for (int i = 0; i < seg_count; i++) begin
                if (seg_used[i]) continue;
                len = 21'(seg_end[i]) - 21'(seg_start[i]) + 1;
                if (len < size) continue;
                if (pick < 0 || (strat == STRAT_BEST && len < pick_len)
                        || (strat == STRAT_WORST && len > pick_len)) begin
                    pick = i;
                    pick_len = len;
                end
                if (strat == STRAT_FIRST) break;
            end
            if (pick < 0) begin
                push(ST_NO_SPACE, 0, 0, 0, 0, 1);
                return;
            end
            if (pick_len > size) begin
                if (seg_count >= TABLE_DEPTH) begin
                    push(ST_FULL, 0, 0, 0, 0, 1);
                    return;
                end
                for (int j = seg_count; j > pick + 1; j--) begin
                    seg_start[j] = seg_start[j-1];
                    seg_end[j] = seg_end[j-1];
                    seg_owner[j] = seg_owner[j-1];
                    seg_used[j] = seg_used[j-1];
                end
                seg_count++;
                seg_start[pick+1] = 20'(seg_start[pick] + size);
                seg_end[pick+1] = seg_end[pick];
                seg_owner[pick+1] = 0;
                seg_used[pick+1] = 0;
                seg_end[pick] = 20'(seg_start[pick] + size - 1);
            end
            seg_used[pick] = 1;
            seg_owner[pick] = id;
            push(ST_OK, seg_start[pick], seg_end[pick], id, 0, 1);
        endfunction

        function void free_owner(bit [7:0] id);
            int i;
            bit [19:0] s, e;
            for (i = 0; i < seg_count; i++)
                if (seg_used[i] && seg_owner[i] == id) break;
            if (i >= seg_count) begin
                push(ST_NO_ID, 0, 0, 0, 0, 1);
                return;
            end
            s = seg_start[i];
            e = seg_end[i];
            seg_used[i] = 0;
            seg_owner[i] = 0;
            if (i + 1 < seg_count && !seg_used[i+1]) begin
                seg_end[i] = seg_end[i+1];
                drop_entry(i + 1);
            end
            if (i > 0 && !seg_used[i-1]) begin
                seg_end[i-1] = seg_end[i];
                drop_entry(i);
            end
            push(ST_OK, s, e, id, 1, 1);
        endfunction

        function void compact();
            int w;
            bit [20:0] addr, len;
            w = 0;
            addr = 0;
            for (int i = 0; i < seg_count; i++) begin
                if (!seg_used[i]) continue;
                len = 21'(seg_end[i]) - 21'(seg_start[i]) + 1;
                seg_start[w] = 20'(addr);
                seg_end[w] = 20'(addr + len - 1);
                seg_owner[w] = seg_owner[i];
                seg_used[w] = 1;
                addr += len;
                w++;
            end
            if (addr < mem_units && w < TABLE_DEPTH) begin
                seg_start[w] = 20'(addr);
                seg_end[w] = 20'(mem_units - 1);
                seg_owner[w] = 0;
                seg_used[w] = 0;
                w++;
            end
            for (int i = w; i < TABLE_DEPTH; i++) begin
                seg_start[i] = 0;
                seg_end[i] = 0;
                seg_owner[i] = 0;
                seg_used[i] = 0;
            end
            seg_count = w;
            push(ST_OK, 0, 0, 0, 0, 1);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, bit [7:0] id, bit [20:0] size,
                                   logic [STRAT_W-1:0] strat);
            case (cmd)
                CMD_REQUEST: allocate(id, size, strat);
                CMD_RELEASE: free_owner(id);
                CMD_COMPACT: compact();
                default: begin
                    for (int i = 0; i < seg_count; i++)
                        push(ST_REPORT, seg_start[i], seg_end[i],
                             seg_used[i] ? seg_owner[i] : 8'd0, !seg_used[i],
                             i + 1 == seg_count);
                end
            endcase
        endfunction

        function void check_result(logic [55:0] data, logic [2:0] user, logic tlast);
            reply_t want, got;
            got.status = user;
            got.start_addr = data[19:0];
            got.end_addr = data[39:20];
            got.owner = data[47:40];
            got.is_free = data[48];
            got.last = tlast;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result status=%0d start=%h end=%h owner=%h free=%b last=%b",
                         $time, got.status, got.start_addr, got.end_addr, got.owner,
                         got.is_free, got.last);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected status=%0d start=%h end=%h owner=%h free=%b last=%b",
                         $time, want.status, want.start_addr, want.end_addr, want.owner,
                         want.is_free, want.last);
                $display("%0t:          actual   status=%0d start=%h end=%h owner=%h free=%b last=%b",
                         $time, got.status, got.start_addr, got.end_addr, got.owner,
                         got.is_free, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wvalid;
    logic        cfg_wready;
    logic [20:0] cfg_wdata;

    segment_table_model table_model;
    int gap_pct;
    int stall_pct;
    int cycle_count;

    contiguous_segment_allocator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wvalid(cfg_wvalid), .cfg_wready(cfg_wready), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready)
            table_model.check_result(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, bit [7:0] id, bit [20:0] size,
                                logic [STRAT_W-1:0] strat);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 0;
            do @(posedge aclk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_tvalid <= 1;
        s_tdata <= {3'b0, size, id};
        s_tuser <= {strat, cmd};
        do @(posedge aclk); while (!s_tready);
        table_model.note_command(cmd, id, size, strat);
    endtask

    task automatic write_mem_size(bit [20:0] v);
        s_tvalid <= 0;
        while (table_model.expected_replies.size() != 0) @(posedge aclk);
        // the table update is finished before the last reply leaves; this wait adds idle time
        repeat (40) @(posedge aclk);
        cfg_wvalid <= 1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_wready);
        cfg_wvalid <= 0;
        table_model.set_mem_size(v);
    endtask

    task automatic random_phase(int n, bit [20:0] mem, int gap, int stall);
        int kind;
        bit [20:0] size;
        bit [7:0] id;
        logic [STRAT_W-1:0] strat;
        write_mem_size(mem);
        gap_pct = gap;
        stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 99);
            id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0, 1: size = 21'($urandom);
                2: size = 21'($urandom_range(1, table_model.mem_units));
                default: size = 21'($urandom_range(1, table_model.mem_units / 8 + 1));
            endcase
            strat = ($urandom_range(0, 19) == 0) ? STRAT_INVALID : 2'($urandom_range(0, 2));
            if (kind < 50) send_request(CMD_REQUEST, id, size, strat);
            else if (kind < 80) send_request(CMD_RELEASE, id, 0, 2'($urandom));
            else if (kind < 90) send_request(CMD_COMPACT, 8'($urandom), 21'($urandom),
                                             STRAT_FIRST);
            else send_request(CMD_REPORT, 8'($urandom), 21'($urandom), 2'($urandom));
        end
    endtask

    initial begin
        table_model = new();
        table_model.set_mem_size(21'h100000);
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        cfg_wvalid = 0;
        cfg_wdata = 0;
        gap_pct = 0;
        stall_pct = 0;
        cycle_count = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        // field extremes and error statuses on the reset table
        send_request(CMD_REPORT, 0, 0, STRAT_FIRST);
        send_request(CMD_REQUEST, 8'd3, 0, STRAT_FIRST);
        send_request(CMD_REQUEST, 8'd3, 21'd5, STRAT_INVALID);
        send_request(CMD_REQUEST, 8'd3, 21'h1FFFFF, STRAT_WORST);
        send_request(CMD_REQUEST, 8'hFF, 21'h100000, STRAT_FIRST);
        send_request(CMD_REPORT, 0, 0, STRAT_FIRST);
        send_request(CMD_RELEASE, 8'h7, 0, STRAT_FIRST);
        send_request(CMD_RELEASE, 8'hFF, 0, STRAT_FIRST);
        send_request(CMD_COMPACT, 0, 0, STRAT_FIRST);

        // fit choice with two holes of different sizes
        write_mem_size(21'd100);
        send_request(CMD_REQUEST, 8'd1, 21'd10, STRAT_FIRST);
        send_request(CMD_REQUEST, 8'd2, 21'd20, STRAT_BEST);
        send_request(CMD_REQUEST, 8'd3, 21'd30, STRAT_WORST);
        send_request(CMD_REQUEST, 8'd4, 21'd40, STRAT_FIRST);
        send_request(CMD_RELEASE, 8'd1, 0, STRAT_FIRST);
        send_request(CMD_RELEASE, 8'd3, 0, STRAT_FIRST);
        send_request(CMD_REQUEST, 8'd5, 21'd5, STRAT_BEST);
        send_request(CMD_REQUEST, 8'd6, 21'd5, STRAT_WORST);
        send_request(CMD_COMPACT, 0, 0, STRAT_FIRST);
        send_request(CMD_REPORT, 0, 0, STRAT_FIRST);

        // fill the table, then a split is refused while an exact fit still works
        write_mem_size(21'd32);
        for (int i = 0; i < 15; i++)
            send_request(CMD_REQUEST, 8'(i + 16), 21'd1, STRAT_FIRST);
        send_request(CMD_REQUEST, 8'd40, 21'd1, STRAT_FIRST);
        send_request(CMD_REQUEST, 8'd41, 21'd17, STRAT_BEST);
        send_request(CMD_REPORT, 0, 0, STRAT_FIRST);
        send_request(CMD_COMPACT, 0, 0, STRAT_FIRST);

        write_mem_size(21'd0);
        send_request(CMD_REQUEST, 8'd9, 21'd1, STRAT_WORST);
        send_request(CMD_REPORT, 0, 0, STRAT_FIRST);

        random_phase(35, 21'd64, 0, 0);
        random_phase(35, 21'h1FFFFF, 77, 0);
        random_phase(35, 21'd300, 0, 77);
        random_phase(35, 21'd1000, 27, 27);

        s_tvalid <= 0;
        while (table_model.expected_replies.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (table_model.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> contiguous_segment_allocator_core.f
rtl/csa_pkg.sv
rtl/csa_cell.sv
rtl/contiguous_segment_allocator_core.sv
bench/tb_top.sv
